// ----- sv/foc_current_loop_svpwm_assert.svh -----
// Assertion macros shared by the checker.
`ifndef FOC_CURRENT_LOOP_SVPWM_ASSERT_SVH
`define FOC_CURRENT_LOOP_SVPWM_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define FOCLS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("focls check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define FOCLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("focls check failed");

`endif

// ----- sv/focls_pkg.sv -----
`default_nettype none
package focls_pkg;

    localparam int unsigned NumRegs = 8;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgW    = 31;

    localparam logic [CfgIdxW-1:0] REG_TORQUE_GAIN  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_FLUX_LINKAGE = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_D_INDUCTANCE = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_Q_INDUCTANCE = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_D_PROP_GAIN  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_D_INT_STEP   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_Q_PROP_GAIN  = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_Q_INT_STEP   = 3'd7;

    localparam logic signed [31:0] MaxPhaseCurrent = 32'sd1310720;
    localparam logic signed [33:0] InvSqrt3   = 34'sd37837;
    localparam logic signed [33:0] VLimit     = 34'sd37838;
    localparam logic signed [33:0] Sqrt3Half  = 34'sd56756;
    localparam logic signed [33:0] NegHalf    = -34'sd32768;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic [30:0] LowBus = 31'd65536;
    localparam logic [30:0] SubBus = 31'd786432;
    localparam logic signed [71:0] Max32 = 72'sd2147483647;
    localparam logic signed [71:0] Min32 = -72'sd2147483648;

    typedef logic signed [71:0] t_wide;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL,
        ST_SQRT,
        ST_MIX,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        S_IBETA, S_ID1, S_ID2, S_IQ1, S_IQ2, S_IQREF, S_DMAX, S_DD1, S_DD2,
        S_QD1, S_QD2, S_DI, S_DP, S_L1, S_L2, S_QI, S_QP, S_UX1, S_UX2,
        S_UY1, S_UY2, S_VB1, S_VB2, S_VC1, S_VC2
    } t_step;

    function automatic logic signed [31:0] f_sat32(input t_wide v);
        if (v > Max32) begin
            return 32'sh7fffffff;
        end else if (v < Min32) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] f_clamp(input logic signed [31:0] v,
                                                   input logic signed [31:0] lim);
        logic signed [31:0] nl;
        nl = -lim;
        if (v > lim) begin
            return lim;
        end else if (v < nl) begin
            return nl;
        end
        return v;
    endfunction

    function automatic logic signed [32:0] f_atan(input logic [3:0] i);
        case (i)
            4'd0:  return 33'sh20000000;
            4'd1:  return 33'sh12E4051E;
            4'd2:  return 33'sh09FB385B;
            4'd3:  return 33'sh051111D4;
            4'd4:  return 33'sh028B0D43;
            4'd5:  return 33'sh0145D7E1;
            4'd6:  return 33'sh00A2F61E;
            4'd7:  return 33'sh00517C55;
            4'd8:  return 33'sh0028BE53;
            4'd9:  return 33'sh00145F2F;
            4'd10: return 33'sh000A2F98;
            4'd11: return 33'sh000517CC;
            4'd12: return 33'sh00028BE6;
            4'd13: return 33'sh000145F3;
            4'd14: return 33'sh0000A2FA;
            default: return 33'sh0000517D;
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- sv/foc_current_loop_svpwm.sv -----
// channel   dir  handshake                         payload
// input     in   i_in_valid / o_in_stall           enable, currents, angle, speed, torque, bus
// output    out  o_out_valid / i_out_stall         duty_phase_a/b/c
// config    in   i_cfg_we, i_cfg_index             i_cfg_data
// An enabled item runs 16 CORDIC steps, 25 multiplier passes, 32 square-root steps for a
// positive q limit, a mix step, three duty divisions and one output load before the next
// item is accepted. A disabled item goes straight to the output load. A finished item
// waits in the output register while the next is worked on; the next one then holds in
// its last state until the register frees.
// Reset (synchronous, low) clears the state, config registers, integrators and the output valid.
`default_nettype none
module foc_current_loop_svpwm (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_enable,
    input  wire logic signed [31:0]            i_phase_a_current,
    input  wire logic signed [31:0]            i_phase_b_current,
    input  wire logic [15:0]                   i_rotor_angle,
    input  wire logic signed [31:0]            i_rotor_speed,
    input  wire logic signed [31:0]            i_torque_request,
    input  wire logic [30:0]                   i_bus_voltage,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [15:0]                        o_duty_phase_a,
    output logic [15:0]                        o_duty_phase_b,
    output logic [15:0]                        o_duty_phase_c,
    input  wire logic                          i_cfg_we,
    input  wire logic [focls_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [focls_pkg::CfgW-1:0]    i_cfg_data
);
    import focls_pkg::*;

    t_state r_state, n_state;
    t_step  r_step;
    logic   r_ph;
    logic [4:0] r_cnt;
    logic [CfgW-1:0] r_cfg [NumRegs];

    logic signed [31:0] r_ia, r_ib, r_spd, r_trq;
    logic [15:0] r_ang;
    logic [30:0] r_bus;
    logic signed [33:0] r_cx, r_cy;
    logic signed [32:0] r_cz;
    logic signed [19:0] r_c, r_s;
    logic signed [67:0] r_prod, r_acc;
    logic signed [31:0] r_ibeta, r_id, r_iq, r_iqref, r_dmax, r_tmp, r_ddec, r_qdec;
    logic signed [31:0] r_dint, r_qint, r_ud, r_uq, r_lim, r_ux, r_uy;
    logic signed [39:0] r_vb, r_vc;
    logic signed [39:0] r_v [3];
    logic [63:0] r_sv, r_sr;
    logic [1:0]  r_dph;
    logic [4:0]  r_dk;
    logic [30:0] r_rem;
    logic [15:0] r_q;
    logic        r_neg, r_sat;
    logic [15:0] r_duty [3];
    logic        r_out_valid;
    logic [15:0] r_oa, r_ob, r_oc;

    logic w_accept, w_load;
    logic signed [33:0] w_dx, w_dy, w_cc, w_ss;
    logic signed [19:0] w_c, w_s;
    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod;
    t_wide w_p72, w_sum, w_dif;
    logic signed [31:0] w_mq, w_errd, w_errq;
    logic [63:0] w_bit, w_trial, w_sv, w_sr;
    logic signed [39:0] w_va, w_vmax, w_vmin, w_off, w_dv, w_dabs;
    logic [30:0] w_udc;
    logic w_dsat, w_qb;
    logic [31:0] w_r2;
    logic [30:0] w_rn;
    logic [15:0] w_qn, w_duty;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_load   = !r_out_valid || !i_out_stall;

    // CORDIC step and quadrant fold
    assign w_dx = r_cy >>> r_cnt[3:0];
    assign w_dy = r_cx >>> r_cnt[3:0];
    assign w_cc = (r_cx + 34'sd8192) >>> 14;
    assign w_ss = (r_cy + 34'sd8192) >>> 14;

    always_comb begin
        case (r_ang[15:14])
            2'd0: begin
                w_c = w_cc[19:0];
                w_s = w_ss[19:0];
            end
            2'd1: begin
                w_c = -w_ss[19:0];
                w_s = w_cc[19:0];
            end
            2'd2: begin
                w_c = -w_cc[19:0];
                w_s = -w_ss[19:0];
            end
            default: begin
                w_c = w_ss[19:0];
                w_s = -w_cc[19:0];
            end
        endcase
    end

    assign w_errd = f_sat32(-t_wide'(r_id));
    assign w_errq = f_sat32(t_wide'(r_iqref) - t_wide'(r_iq));

    // shared multiplier operands
    always_comb begin
        case (r_step)
            S_IBETA: begin w_ma = 34'(r_ia) + (34'(r_ib) <<< 1); w_mb = InvSqrt3; end
            S_ID1:   begin w_ma = 34'(r_ia);    w_mb = 34'(r_c); end
            S_ID2:   begin w_ma = 34'(r_ibeta); w_mb = 34'(r_s); end
            S_IQ1:   begin w_ma = 34'(r_ibeta); w_mb = 34'(r_c); end
            S_IQ2:   begin w_ma = 34'(r_ia);    w_mb = 34'(r_s); end
            S_IQREF: begin w_ma = 34'(r_trq);   w_mb = 34'(r_cfg[REG_TORQUE_GAIN]); end
            S_DMAX:  begin w_ma = 34'(r_bus);   w_mb = VLimit; end
            S_DD1:   begin w_ma = 34'(r_spd);   w_mb = 34'(r_cfg[REG_Q_INDUCTANCE]); end
            S_DD2:   begin w_ma = 34'(r_tmp);   w_mb = 34'(r_iq); end
            S_QD1:   begin w_ma = 34'(r_cfg[REG_D_INDUCTANCE]); w_mb = 34'(r_id); end
            S_QD2:   begin w_ma = 34'(r_spd);   w_mb = 34'(r_tmp); end
            S_DI:    begin w_ma = 34'(r_cfg[REG_D_INT_STEP]);  w_mb = 34'(w_errd); end
            S_DP:    begin w_ma = 34'(r_cfg[REG_D_PROP_GAIN]); w_mb = 34'(w_errd); end
            S_L1:    begin w_ma = 34'(r_dmax);  w_mb = 34'(r_dmax); end
            S_L2:    begin w_ma = 34'(r_ud);    w_mb = 34'(r_ud); end
            S_QI:    begin w_ma = 34'(r_cfg[REG_Q_INT_STEP]);  w_mb = 34'(w_errq); end
            S_QP:    begin w_ma = 34'(r_cfg[REG_Q_PROP_GAIN]); w_mb = 34'(w_errq); end
            S_UX1:   begin w_ma = 34'(r_ud);    w_mb = 34'(r_c); end
            S_UX2:   begin w_ma = 34'(r_uq);    w_mb = 34'(r_s); end
            S_UY1:   begin w_ma = 34'(r_ud);    w_mb = 34'(r_s); end
            S_UY2:   begin w_ma = 34'(r_uq);    w_mb = 34'(r_c); end
            S_VB1:   begin w_ma = 34'(r_ux);    w_mb = NegHalf; end
            S_VB2:   begin w_ma = 34'(r_uy);    w_mb = Sqrt3Half; end
            S_VC1:   begin w_ma = 34'(r_ux);    w_mb = NegHalf; end
            S_VC2:   begin w_ma = 34'(r_uy);    w_mb = Sqrt3Half; end
            default: begin w_ma = '0;           w_mb = '0; end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_p72  = t_wide'(r_prod);
    assign w_mq   = f_sat32(w_p72 >>> 16);
    assign w_sum  = t_wide'(r_acc) + w_p72;
    assign w_dif  = t_wide'(r_acc) - w_p72;

    // square root step
    assign w_bit   = 64'd1 << (6'd62 - {r_cnt, 1'b0});
    assign w_trial = r_sr + w_bit;
    always_comb begin
        if (r_sv >= w_trial) begin
            w_sv = r_sv - w_trial;
            w_sr = (r_sr >> 1) + w_bit;
        end else begin
            w_sv = r_sv;
            w_sr = r_sr >> 1;
        end
    end

    // midpoint offset
    assign w_va = 40'(r_ux);
    always_comb begin
        w_vmax = w_va;
        w_vmin = w_va;
        if (r_vb > w_vmax) w_vmax = r_vb;
        if (r_vc > w_vmax) w_vmax = r_vc;
        if (r_vb < w_vmin) w_vmin = r_vb;
        if (r_vc < w_vmin) w_vmin = r_vc;
        w_off = -((w_vmax + w_vmin) >>> 1);
    end

    // duty division
    assign w_udc  = (r_bus < LowBus) ? SubBus : r_bus;
    assign w_dv   = r_v[r_dph];
    assign w_dabs = w_dv[39] ? -w_dv : w_dv;
    assign w_dsat = w_dabs >= 40'(w_udc);
    assign w_r2   = {r_rem, 1'b0};
    assign w_qb   = w_r2 >= 32'(w_udc);
    assign w_rn   = w_qb ? 31'(w_r2 - 32'(w_udc)) : w_r2[30:0];
    assign w_qn   = {r_q[14:0], w_qb};

    always_comb begin
        if (r_neg) begin
            w_duty = (r_sat || r_q > 16'd32768) ? 16'd0 : 16'd32768 - r_q;
        end else begin
            w_duty = (r_sat || r_q[15]) ? 16'hffff : 16'd32768 + r_q;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = i_enable ? ST_CORDIC : ST_DONE;
            end
            ST_CORDIC: begin
                if (r_cnt == 5'd15) n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_ph) begin
                    if (r_step == S_L2 && w_dif > 72'sd0) n_state = ST_SQRT;
                    else if (r_step == S_VC2) n_state = ST_MIX;
                end
            end
            ST_SQRT: begin
                if (r_cnt == 5'd31) n_state = ST_MUL;
            end
            ST_MIX: n_state = ST_DIV;
            ST_DIV: begin
                if (r_dk == 5'd17 && r_dph == 2'd2) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall     = (r_state != ST_IDLE);
        o_out_valid    = r_out_valid;
        o_duty_phase_a = r_oa;
        o_duty_phase_b = r_ob;
        o_duty_phase_c = r_oc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NumRegs; i++) r_cfg[i] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg[i_cfg_index] <= i_cfg_data;
            if (r_state == ST_DONE && w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_load) begin
            r_oa <= r_duty[0];
            r_ob <= r_duty[1];
            r_oc <= r_duty[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dint <= '0;
            r_qint <= '0;
            r_step <= S_IBETA;
            r_ph   <= 1'b0;
            r_cnt  <= '0;
            r_dph  <= '0;
            r_dk   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_ia  <= i_phase_a_current;
                        r_ib  <= i_phase_b_current;
                        r_ang <= i_rotor_angle;
                        r_spd <= i_rotor_speed;
                        r_trq <= i_torque_request;
                        r_bus <= i_bus_voltage;
                        r_cx  <= CordicGain;
                        r_cy  <= '0;
                        r_cz  <= 33'({i_rotor_angle[13:0], 16'd0});
                        r_cnt <= '0;
                        r_step <= S_IBETA;
                        r_ph  <= 1'b0;
                        r_dph <= '0;
                        r_dk  <= '0;
                        if (!i_enable) begin
                            r_dint <= '0;
                            r_qint <= '0;
                            for (int i = 0; i < 3; i++) r_duty[i] <= '0;
                        end
                    end
                end
                ST_CORDIC: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (!r_cz[32]) begin
                        r_cx <= r_cx - w_dx;
                        r_cy <= r_cy + w_dy;
                        r_cz <= r_cz - f_atan(r_cnt[3:0]);
                    end else begin
                        r_cx <= r_cx + w_dx;
                        r_cy <= r_cy - w_dy;
                        r_cz <= r_cz + f_atan(r_cnt[3:0]);
                    end
                end
                ST_MUL: begin
                    r_ph <= ~r_ph;
                    if (!r_ph) begin
                        r_prod <= w_prod;
                        if (r_step == S_IBETA) begin
                            r_c <= w_c;
                            r_s <= w_s;
                        end
                    end else begin
                        if (r_step != S_VC2) r_step <= t_step'(5'(r_step) + 5'd1);
                        case (r_step)
                            S_IBETA: r_ibeta <= w_mq;
                            S_ID2:   r_id    <= f_sat32(w_sum >>> 16);
                            S_IQ2:   r_iq    <= f_sat32(w_dif >>> 16);
                            S_IQREF: r_iqref <= f_clamp(w_mq, MaxPhaseCurrent);
                            S_DMAX:  r_dmax  <= w_mq;
                            S_DD1:   r_tmp   <= w_mq;
                            S_DD2:   r_ddec  <= f_sat32(-t_wide'(w_mq));
                            S_QD1:   r_tmp   <= f_sat32(t_wide'(w_mq)
                                                + t_wide'(r_cfg[REG_FLUX_LINKAGE]));
                            S_QD2:   r_qdec  <= w_mq;
                            S_DI:    r_dint  <= f_clamp(f_sat32(t_wide'(r_dint)
                                                + t_wide'(w_mq)), r_dmax);
                            S_DP:    r_ud    <= f_clamp(f_sat32(t_wide'(w_mq)
                                                + t_wide'(r_dint) + t_wide'(r_ddec)), r_dmax);
                            S_L2: begin
                                r_lim <= '0;
                                r_sv  <= w_dif[63:0];
                                r_sr  <= '0;
                                r_cnt <= '0;
                            end
                            S_QI:    r_qint  <= f_clamp(f_sat32(t_wide'(r_qint)
                                                + t_wide'(w_mq)), r_lim);
                            S_QP:    r_uq    <= f_clamp(f_sat32(t_wide'(w_mq)
                                                + t_wide'(r_qint) + t_wide'(r_qdec)), r_lim);
                            S_UX2:   r_ux    <= f_sat32(w_dif >>> 16);
                            S_UY2:   r_uy    <= f_sat32(w_sum >>> 16);
                            S_VB2:   r_vb    <= 40'(w_sum >>> 16);
                            S_VC2:   r_vc    <= 40'(w_dif >>> 16);
                            default: r_acc   <= r_prod;
                        endcase
                    end
                end
                ST_SQRT: begin
                    r_cnt <= r_cnt + 5'd1;
                    r_sv  <= w_sv;
                    r_sr  <= w_sr;
                    if (r_cnt == 5'd31) r_lim <= w_sr[31:0];
                end
                ST_MIX: begin
                    r_v[0] <= w_va + w_off;
                    r_v[1] <= r_vb + w_off;
                    r_v[2] <= r_vc + w_off;
                    r_dk   <= '0;
                    r_dph  <= '0;
                end
                ST_DIV: begin
                    if (r_dk == 5'd0) begin
                        r_rem <= w_dabs[30:0];
                        r_neg <= w_dv[39];
                        r_sat <= w_dsat;
                        r_q   <= '0;
                        r_dk  <= r_dk + 5'd1;
                    end else if (r_dk == 5'd17) begin
                        r_duty[r_dph] <= w_duty;
                        r_dk  <= '0;
                        r_dph <= r_dph + 2'd1;
                    end else begin
                        r_rem <= w_rn;
                        r_q   <= w_qn;
                        r_dk  <= r_dk + 5'd1;
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sv/focls_chk.sv -----
`default_nettype none
`include "foc_current_loop_svpwm_assert.svh"
module focls_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_enable,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [15:0] o_duty_phase_a,
    input wire logic [15:0] o_duty_phase_b,
    input wire logic [15:0] o_duty_phase_c
);
    logic w_acc;
    assign w_acc = i_in_valid && !o_in_stall;

    `FOCLS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `FOCLS_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall,
        $stable(o_duty_phase_a) && $stable(o_duty_phase_b) && $stable(o_duty_phase_c))
    `FOCLS_ASSERT_NEXT(a_busy_after_accept, w_acc, o_in_stall)
    `FOCLS_ASSERT_NEXT(a_no_early_result, w_acc && i_enable, !$rose(o_out_valid))
endmodule

bind foc_current_loop_svpwm focls_chk u_focls_chk (.*);
`default_nettype wire
